/* src/qosm_pkg.sv */
// Package for the quote order slot manager: constants, codes, types.
// No dependencies.
package qosm_pkg;
  localparam int SLOTS = 4;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] OP_QUOTE = 3'd0;
  localparam logic [2:0] OP_EXEC = 3'd1;
  localparam logic [2:0] OP_RESYNC = 3'd2;
  localparam logic [2:0] OP_ROW = 3'd3;
  localparam logic [2:0] OP_CXL_ALL = 3'd4;

  localparam logic [2:0] EX_ACK = 3'd0;
  localparam logic [2:0] EX_PARTIAL = 3'd1;
  localparam logic [2:0] EX_FILLED = 3'd2;
  localparam logic [2:0] EX_CANCELED = 3'd3;
  localparam logic [2:0] EX_REJECTED = 3'd4;
  localparam logic [2:0] EX_EXPIRED = 3'd5;

  localparam logic [1:0] CMD_PLACE = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_CXL_ALL = 2'd2;

  localparam logic [1:0] ST_PENDING_NEW = 2'd0;
  localparam logic [1:0] ST_WORKING = 2'd1;
  localparam logic [1:0] ST_PARTIAL = 2'd2;
  localparam logic [1:0] ST_PENDING_CANCEL = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_DONE} state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [62:0] timestamp;
    logic [31:0] cl_ord_id;
    logic [2:0] exec_kind;
    logic [63:0] venue_ord_id;
    logic [31:0] cum_quantity;
  } in_word_t;

  typedef struct packed {
    logic command_valid;
    logic [1:0] command_kind;
    logic [31:0] sequence_res;
    logic [31:0] command_client_id;
    logic command_side;
    logic [31:0] command_price;
    logic [31:0] command_quantity;
    logic [62:0] command_time;
    logic [2:0] open_slots;
    logic all_flat;
  } out_word_t;
endpackage

/* src/qosm_stream_if.sv */
// Valid/ready channel carrying one word of a given packed type.
// Depends on qosm_pkg only through the type passed in.
interface qosm_stream_if #(parameter type word_t = logic) ();
  logic valid;
  logic ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/quote_order_slot_manager_unit.sv */
// Top level of the quote order slot manager.
// Depends on qosm_pkg and qosm_stream_if.
//
//  channel | direction | content
//  in_     | sink      | one request word (quote, exec, resync, row, cancel all)
//  out_    | source    | one result word per request
//  cfg_    | write     | first_client_id
//
// A word goes through capture, a slot scan with a shared compare unit (one
// slot per cycle), an update in S_EXEC that registers its result, and S_DONE,
// after which the result is valid. The block is not ready while a word is at
// work or while its result waits in the output register, so a new word is not
// accepted until the last result is taken. Reset is synchronous, clears the
// slot valid bits, sequence counter and output valid, and sets the client id counter to 1.
module quote_order_slot_manager_unit (
  input  logic clk,
  input  logic rst_n,
  qosm_stream_if.sink in_ch,
  qosm_stream_if.source out_ch,
  input  logic cfg_we,
  input  logic [31:0] cfg_wdata
);
  import qosm_pkg::*;

  state_t state_r, state_nxt;
  in_word_t req_r;
  out_word_t res_r, res_nxt;
  logic out_valid_r;
  logic [SLOT_W-1:0] idx_r;
  logic side_hit_r, cid_hit_r, free_hit_r;
  logic [SLOT_W-1:0] side_k_r, cid_k_r, free_k_r;
  logic [SLOTS-1:0] act_r;
  logic [31:0] cli_r [SLOTS];
  logic [63:0] xid_r [SLOTS];
  logic [31:0] px_r [SLOTS];
  logic [31:0] qty_r [SLOTS];
  logic [31:0] fil_r [SLOTS];
  logic sd_r [SLOTS];
  logic [1:0] st_r [SLOTS];
  logic [31:0] seq_r, cli_cnt_r;
  logic last;

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign last = (idx_r == SLOT_W'(SLOTS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_SCAN;
      S_SCAN: if (last) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Shared compare unit: one slot per scan cycle, first match kept.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      idx_r <= '0;
      side_hit_r <= 1'b0;
      cid_hit_r <= 1'b0;
      free_hit_r <= 1'b0;
      if (in_ch.valid && in_ch.ready) req_r <= in_ch.data;
    end else if (state_r == S_SCAN) begin
      if (!last) idx_r <= idx_r + 1'b1;
      if (act_r[idx_r] && sd_r[idx_r] == req_r.side && !side_hit_r) begin
        side_hit_r <= 1'b1;
        side_k_r <= idx_r;
      end
      if (act_r[idx_r] && cli_r[idx_r] == req_r.cl_ord_id && !cid_hit_r) begin
        cid_hit_r <= 1'b1;
        cid_k_r <= idx_r;
      end
      if (!act_r[idx_r] && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_k_r <= idx_r;
      end
    end
  end

  logic [SLOT_W:0] cnt;
  always_comb begin
    cnt = '0;
    for (int i = 0; i < SLOTS; i++) cnt = cnt + (SLOT_W+1)'(act_r[i]);
  end

  // The counts come straight from the valid bits, which hold still while a
  // result waits.
  always_comb begin
    out_ch.data = res_r;
    out_ch.data.open_slots = (cnt > 7) ? 3'd7 : 3'(cnt);
    out_ch.data.all_flat = (cnt == '0);
  end

  // Command of the word under update; all command fields stay zero without one.
  always_comb begin
    res_nxt = '0;
    unique case (req_r.operation)
      OP_QUOTE: begin
        if (req_r.price == '0) begin
          if (side_hit_r && st_r[side_k_r] != ST_PENDING_CANCEL) begin
            res_nxt.command_valid = 1'b1;
            res_nxt.command_kind = CMD_CANCEL;
            res_nxt.sequence_res = seq_r;
            res_nxt.command_client_id = cli_r[side_k_r];
            res_nxt.command_side = sd_r[side_k_r];
            res_nxt.command_time = req_r.timestamp;
          end
        end else if (!side_hit_r) begin
          if (free_hit_r) begin
            res_nxt.command_valid = 1'b1;
            res_nxt.command_kind = CMD_PLACE;
            res_nxt.sequence_res = seq_r;
            res_nxt.command_client_id = cli_cnt_r;
            res_nxt.command_side = req_r.side;
            res_nxt.command_price = req_r.price;
            res_nxt.command_quantity = req_r.quantity;
            res_nxt.command_time = req_r.timestamp;
          end
        end else if (st_r[side_k_r] != ST_PENDING_CANCEL &&
                     (px_r[side_k_r] != req_r.price ||
                      qty_r[side_k_r] != req_r.quantity)) begin
          res_nxt.command_valid = 1'b1;
          res_nxt.command_kind = CMD_CANCEL;
          res_nxt.sequence_res = seq_r;
          res_nxt.command_client_id = cli_r[side_k_r];
          res_nxt.command_side = sd_r[side_k_r];
          res_nxt.command_time = req_r.timestamp;
        end
      end
      OP_CXL_ALL: begin
        res_nxt.command_valid = 1'b1;
        res_nxt.command_kind = CMD_CXL_ALL;
        res_nxt.sequence_res = seq_r;
        res_nxt.command_time = req_r.timestamp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      seq_r <= '0;
      cli_cnt_r <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cli_cnt_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == S_EXEC) begin
        res_r <= res_nxt;
        if (res_nxt.command_valid) seq_r <= seq_r + 1'b1;
        unique case (req_r.operation)
          OP_QUOTE: begin
            if (res_nxt.command_valid && res_nxt.command_kind == CMD_PLACE) begin
              cli_cnt_r <= cli_cnt_r + 1'b1;
              act_r[free_k_r] <= 1'b1;
              cli_r[free_k_r] <= cli_cnt_r;
              xid_r[free_k_r] <= '0;
              px_r[free_k_r] <= req_r.price;
              qty_r[free_k_r] <= req_r.quantity;
              fil_r[free_k_r] <= '0;
              sd_r[free_k_r] <= req_r.side;
              st_r[free_k_r] <= ST_PENDING_NEW;
            end else if (res_nxt.command_valid) begin
              st_r[side_k_r] <= ST_PENDING_CANCEL;
            end
          end
          OP_EXEC: begin
            if (cid_hit_r) begin
              if (req_r.exec_kind == EX_ACK) begin
                st_r[cid_k_r] <= ST_WORKING;
                xid_r[cid_k_r] <= req_r.venue_ord_id;
              end else if (req_r.exec_kind == EX_PARTIAL) begin
                st_r[cid_k_r] <= ST_PARTIAL;
                xid_r[cid_k_r] <= req_r.venue_ord_id;
                fil_r[cid_k_r] <= req_r.cum_quantity;
              end else if (req_r.exec_kind <= EX_EXPIRED) begin
                act_r[cid_k_r] <= 1'b0;
              end
            end
          end
          OP_RESYNC: act_r <= '0;
          OP_ROW: begin
            if (free_hit_r) begin
              act_r[free_k_r] <= 1'b1;
              cli_r[free_k_r] <= req_r.cl_ord_id;
              xid_r[free_k_r] <= req_r.venue_ord_id;
              px_r[free_k_r] <= req_r.price;
              qty_r[free_k_r] <= req_r.quantity;
              fil_r[free_k_r] <= req_r.cum_quantity;
              sd_r[free_k_r] <= req_r.side;
              st_r[free_k_r] <= (req_r.cum_quantity != '0) ? ST_PARTIAL : ST_WORKING;
            end
          end
          OP_CXL_ALL: begin
            for (int i = 0; i < SLOTS; i++)
              if (act_r[i]) st_r[i] <= ST_PENDING_CANCEL;
          end
          default: ;
        endcase
      end
      if (state_r == S_DONE) out_valid_r <= 1'b1;
    end
  end
endmodule
